// ===== design/bta_pkg.sv =====
// shared constants, codes and types for the bakery ticket arbiter
package bta_pkg;

    localparam int THREADS     = 8;
    localparam int TICKET_BITS = 16;
    localparam int THREAD_BITS = $clog2(THREADS);
    localparam int N_BITS      = $clog2(THREADS + 1);

    localparam int CFG_BITS    = 4;
    localparam int TID_BITS    = 3;
    localparam int OUT_TKT     = 16;
    localparam int STATUS_BITS = 3;
    localparam int IN_BYTES_W  = 8;
    localparam int OUT_BYTES_W = 24;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_REPEAT    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NO_TICKET = 3'd4;

    typedef logic [TICKET_BITS-1:0] ticket_t;
    typedef logic [THREAD_BITS-1:0] thread_idx_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic mode_min;
    } scan_ctrl_t;

endpackage

// ===== design/bta_ticket_store.sv =====
// ticket table: one entry per thread, one read and one write port
module bta_ticket_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bta_pkg::thread_idx_t rd_idx,
    output bta_pkg::ticket_t     rd_data,
    input  logic                 wr_en,
    input  bta_pkg::thread_idx_t wr_idx,
    input  bta_pkg::ticket_t     wr_data
);
    import bta_pkg::*;

    ticket_t table_reg [THREADS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            table_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = table_reg[rd_idx];

endmodule

// ===== design/bta_scan_unit.sv =====
// shared compare unit that walks the table for the largest or smallest ticket
module bta_scan_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bta_pkg::scan_ctrl_t  ctrl,
    input  bta_pkg::ticket_t     entry,
    input  bta_pkg::thread_idx_t idx,
    output bta_pkg::ticket_t     acc,
    output logic                 acc_valid,
    output bta_pkg::thread_idx_t acc_idx
);
    import bta_pkg::*;

    ticket_t     acc_reg;
    ticket_t     acc_next;
    logic        acc_valid_reg;
    logic        acc_valid_next;
    thread_idx_t acc_idx_reg;
    thread_idx_t acc_idx_next;
    ticket_t     cmp_a;
    ticket_t     cmp_b;
    logic        cmp_lt;
    logic        take;

    // one comparator serves both walks
    always_comb
    begin
        cmp_a  = ctrl.mode_min ? entry : acc_reg;
        cmp_b  = ctrl.mode_min ? acc_reg : entry;
        cmp_lt = cmp_a < cmp_b;
        if (ctrl.mode_min)
        begin
            take = (entry != '0) && (!acc_valid_reg || cmp_lt);
        end
        else
        begin
            take = cmp_lt;
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        acc_valid_next = acc_valid_reg;
        acc_idx_next   = acc_idx_reg;
        if (ctrl.clear)
        begin
            acc_next       = '0;
            acc_valid_next = 1'b0;
            acc_idx_next   = '0;
        end
        else if (ctrl.step && take)
        begin
            acc_next       = entry;
            acc_valid_next = 1'b1;
            acc_idx_next   = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= acc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        acc_idx_reg <= acc_idx_next;
    end

    assign acc       = acc_reg;
    assign acc_valid = acc_valid_reg;
    assign acc_idx   = acc_idx_reg;

endmodule

// ===== design/bakery_ticket_arbiter.sv =====
// top level: sequencer of the bakery ticket arbiter
//
//  channel  | handshake                | payload
//  s_axis   | s_axis_tvalid/tready     | s_axis_tdata: opcode, thread_id
//  m_axis   | m_axis_tvalid/tready     | m_axis_tdata: ticket, grant_valid, grant_thread, status
//  cfg      | cfg_valid/cfg_ready      | cfg_data: active_threads
//
//  a granted request is checked, then one comparator walks the n active entries for the
//  maximum, the ticket is written, and the comparator walks them again for the minimum;
//  releases skip the max walk, refused words the write too (no walk with no active thread)
//  reset clears the table to no tickets and sets the active count to 8
//  ready rises as each result is loaded, even while that result waits;
//  the next finished word then holds its last step until the output register is free
module bakery_ticket_arbiter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bta_pkg::IN_BYTES_W-1:0]   s_axis_tdata,  // opcode, thread_id, zero fill
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bta_pkg::OUT_BYTES_W-1:0] m_axis_tdata, // ticket, grant_valid, grant_thread, status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bta_pkg::CFG_BITS-1:0]     cfg_data
);
    import bta_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MAX   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_MIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [CFG_BITS-1:0]      active_reg;
    logic [CFG_BITS-1:0]      active_next;
    logic                     op_reg;
    logic [TID_BITS-1:0]      tid_reg;
    logic [N_BITS-1:0]        n_reg;
    logic [N_BITS-1:0]        n_cur;
    thread_idx_t              idx_reg;
    thread_idx_t              idx_next;
    ticket_t                  given_reg;
    ticket_t                  given_next;
    logic [STATUS_BITS-1:0]   status_reg;
    logic [STATUS_BITS-1:0]   status_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [OUT_BYTES_W-1:0]   out_data_reg;
    logic [OUT_BYTES_W-1:0]   out_data_next;

    logic                     in_fire;
    logic                     last_idx;
    logic                     out_free;
    thread_idx_t              tid_idx;
    thread_idx_t              rd_idx;
    ticket_t                  rd_data;
    logic                     wr_en;
    ticket_t                  wr_data;
    scan_ctrl_t               scan_ctrl;
    ticket_t                  scan_acc;
    logic                     scan_valid;
    thread_idx_t              scan_idx;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign tid_idx       = THREAD_BITS'(tid_reg);
    assign last_idx      = ({1'b0, idx_reg} == N_BITS'(n_reg - 1'b1));
    assign rd_idx        = (state_reg == S_CHECK) ? tid_idx : idx_reg;

    always_comb
    begin
        if (active_reg > CFG_BITS'(THREADS))
        begin
            n_cur = N_BITS'(THREADS);
        end
        else
        begin
            n_cur = N_BITS'(active_reg);
        end
    end

    assign active_next = (cfg_valid && cfg_ready) ? cfg_data : active_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        given_next     = given_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_data        = '0;
        scan_ctrl      = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                idx_next        = '0;
                given_next      = '0;
                scan_ctrl.clear = 1'b1;
                priority if ({1'b0, tid_reg} >= (TID_BITS + 1)'(n_reg))
                begin
                    status_next = ST_BAD_INDEX;
                    // no active thread: nothing to walk
                    state_next  = (n_reg == '0) ? S_DONE : S_MIN;
                end
                else if (op_reg == OP_REQUEST && rd_data != '0)
                begin
                    status_next = ST_REPEAT;
                    state_next  = S_MIN;
                end
                else if (op_reg == OP_RELEASE && rd_data == '0)
                begin
                    status_next = ST_NO_TICKET;
                    state_next  = S_MIN;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = (op_reg == OP_REQUEST) ? S_MAX : S_WRITE;
                end
            end
            S_MAX:
            begin
                scan_ctrl.step = 1'b1;
                if (last_idx)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                wr_en           = 1'b1;
                idx_next        = '0;
                scan_ctrl.clear = 1'b1;
                if (op_reg == OP_RELEASE)
                begin
                    wr_data = '0;
                end
                else if (scan_acc == '1)
                begin
                    wr_data     = '1;
                    given_next  = '1;
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_data    = scan_acc + 1'b1;
                    given_next = scan_acc + 1'b1;
                end
                state_next = S_MIN;
            end
            S_MIN:
            begin
                scan_ctrl.step     = 1'b1;
                scan_ctrl.mode_min = 1'b1;
                if (last_idx)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                scan_ctrl.mode_min = 1'b1;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_BYTES_W'({status_reg,
                                                   scan_valid ? TID_BITS'(scan_idx)
                                                              : TID_BITS'(0),
                                                   scan_valid,
                                                   OUT_TKT'(given_reg)});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= s_axis_tdata[0];
            tid_reg <= s_axis_tdata[TID_BITS:1];
            n_reg   <= n_cur;
        end
        idx_reg      <= idx_next;
        given_reg    <= given_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    bta_ticket_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (tid_idx),
        .wr_data (wr_data)
    );

    bta_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .entry     (rd_data),
        .idx       (idx_reg),
        .acc       (scan_acc),
        .acc_valid (scan_valid),
        .acc_idx   (scan_idx)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_CHECK)
        else $error("accepted word did not start the table check");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAX || state_reg == S_MIN) |-> {1'b0, idx_reg} < n_reg)
        else $error("table walk beyond the active threads");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[OUT_TKT+TID_BITS+1 +: STATUS_BITS] == ST_OVERFLOW)
        |-> out_data_reg[OUT_TKT-1:0] == OUT_TKT'(ticket_t'('1)))
        else $error("overflow result without a saturated ticket");

    a_refused_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[OUT_TKT+TID_BITS+1 +: STATUS_BITS] == ST_BAD_INDEX
                        || out_data_reg[OUT_TKT+TID_BITS+1 +: STATUS_BITS] == ST_REPEAT))
        |-> out_data_reg[OUT_TKT-1:0] == '0)
        else $error("refused request handed out a ticket");
`endif

endmodule

// ===== dv/bakery_ticket_arbiter_test.sv =====
// testbench for the bakery ticket arbiter: directed and random word streams
`timescale 1ns / 1ps

module bakery_ticket_arbiter_test;
    import bta_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic                   fill;
        logic [STATUS_BITS-1:0] status;
        thread_idx_t            grant_thread;
        logic                   grant_valid;
        ticket_t                ticket;
    } grant_word_t;

    class ticket_book;
        ticket_t             tickets[THREADS];
        logic [CFG_BITS-1:0] thread_count;
        grant_word_t         expected_q[$];
        int                  fail_count;

        function new();
            foreach (tickets[j])
                tickets[j] = '0;
            thread_count = CFG_RESET;
            fail_count = 0;
        endfunction

        function void set_count(logic [CFG_BITS-1:0] value);
            thread_count = value;
        endfunction

        function int live_count();
            return (thread_count > THREADS) ? THREADS : int'(thread_count);
        endfunction

        function void note_word(logic op, thread_idx_t tid);
            int          n;
            ticket_t     top;
            ticket_t     best;
            logic        found;
            grant_word_t w;
            n = live_count();
            w = '0;
            if (int'(tid) >= n)
                w.status = ST_BAD_INDEX;
            else if (op == OP_REQUEST)
            begin
                if (tickets[tid] != '0)
                    w.status = ST_REPEAT;
                else
                begin
                    top = '0;
                    for (int j = 0; j < n; j++)
                        if (tickets[j] > top)
                            top = tickets[j];
                    if (top == '1)
                    begin
                        w.ticket = '1;
                        w.status = ST_OVERFLOW;
                    end
                    else
                        w.ticket = top + 1'b1;
                    tickets[tid] = w.ticket;
                end
            end
            else if (tickets[tid] == '0)
                w.status = ST_NO_TICKET;
            else
                tickets[tid] = '0;
            found = 1'b0;
            best = '0;
            for (int j = 0; j < n; j++)
                if (tickets[j] != '0 && (!found || tickets[j] < best))
                begin
                    found = 1'b1;
                    best = tickets[j];
                    w.grant_thread = thread_idx_t'(j);
                end
            w.grant_valid = found;
            expected_q.push_back(w);
        endfunction

        function void check_grant(logic [OUT_BYTES_W-1:0] data);
            grant_word_t got;
            grant_word_t want;
            got = data;
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word %h", data);
                return;
            end
            want = expected_q.pop_front();
            if (got.ticket !== want.ticket || got.grant_valid !== want.grant_valid ||
                got.grant_thread !== want.grant_thread || got.status !== want.status)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: ticket %0d/%0d valid %b/%b thread %0d/%0d status %0d/%0d",
                             want.ticket, got.ticket, want.grant_valid, got.grant_valid,
                             want.grant_thread, got.grant_thread, want.status, got.status);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_BYTES_W-1:0]    s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_BYTES_W-1:0]   m_axis_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_BITS-1:0]      cfg_data;

    logic                     pressure_armed;
    int                       sender_idle_pct;
    int                       sink_stall_pct;
    ticket_book               book = new();

    bakery_ticket_arbiter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("bakery_ticket_arbiter verification failed");
        $finish;
    end

    // result side: check each accepted word, then pick next tready
    initial
    begin : result_sink
        int   hold_left;
        logic pressure_done;
        hold_left = 0;
        pressure_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                book.check_grant(m_axis_tdata);
            if (pressure_armed && !pressure_done)
            begin
                hold_left = 500;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_word(input logic op, input thread_idx_t tid);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, tid, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        book.note_word(op, tid);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (book.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_thread_count(input logic [CFG_BITS-1:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.set_count(value);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 45; end
            default: begin sender_idle_pct = 25; sink_stall_pct = 25; end
        endcase
    endtask

    task automatic release_all();
        for (int j = 0; j < THREADS; j++)
            send_word(OP_RELEASE, thread_idx_t'(j));
    endtask

    task automatic run_random(input int count);
        logic        op;
        thread_idx_t tid;
        int          n;
        n = book.live_count();
        for (int k = 0; k < count; k++)
        begin
            if (n > 0 && $urandom_range(99) < 85)
            begin
                tid = thread_idx_t'($urandom_range(n - 1));
                if (book.tickets[tid] != '0)
                    op = ($urandom_range(99) < 75) ? OP_RELEASE : OP_REQUEST;
                else
                    op = ($urandom_range(99) < 80) ? OP_REQUEST : OP_RELEASE;
            end
            else
            begin
                op  = 1'($urandom_range(1));
                tid = thread_idx_t'($urandom_range(THREADS - 1));
            end
            send_word(op, tid);
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_BITS-1:0] counts[12];
        counts = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd6, 4'd0, 4'd5, 4'd8, 4'd12, 4'd2, 4'd7, 4'd4};
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        pressure_armed <= 1'b0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals, ordering, saturated and zero counts, inactive holders
        send_word(OP_RELEASE, 3'd0);
        send_word(OP_REQUEST, 3'd7);
        send_word(OP_REQUEST, 3'd0);
        send_word(OP_REQUEST, 3'd0);
        send_word(OP_REQUEST, 3'd3);
        send_word(OP_RELEASE, 3'd7);
        set_thread_count(4'd15);
        send_word(OP_REQUEST, 3'd6);
        set_thread_count(4'd3);
        send_word(OP_REQUEST, 3'd1);
        send_word(OP_REQUEST, 3'd5);
        send_word(OP_RELEASE, 3'd6);
        set_thread_count(4'd0);
        send_word(OP_REQUEST, 3'd0);
        send_word(OP_RELEASE, 3'd2);
        set_thread_count(4'd8);
        send_word(OP_REQUEST, 3'd2);
        release_all();

        for (int seg = 0; seg < 12; seg++)
        begin
            set_thread_count(counts[seg]);
            set_idling(seg % 4);
            if (seg == 2)
                pressure_armed <= 1'b1;
            run_random(160);
        end

        wait_quiet();
        repeat (60) @(posedge clk);
        book.fail_count += book.expected_q.size();
        if (book.fail_count == 0)
            $display("bakery_ticket_arbiter verification clean");
        else
            $display("bakery_ticket_arbiter verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bta_pkg.sv
design/bta_ticket_store.sv
design/bta_scan_unit.sv
design/bakery_ticket_arbiter.sv
dv/bakery_ticket_arbiter_test.sv
